FILE: design/mau_pkg.sv
package mau_pkg;

  localparam int MOD_WIDTH_DEF = 31;
  localparam int EXP_WIDTH_DEF = 63;
  localparam logic [63:0] MODULUS_RESET = 64'd998244353;
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_POW = 3'd4,
    MODE_INV = 3'd5
  } mode_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED_STEP,
    DP_SAVE_A,
    DP_SAVE_B,
    DP_ADD,
    DP_SUB,
    DP_ZERO,
    DP_POW_A,
    DP_POW_INV_A,
    DP_POW_INV_B,
    DP_MUL_ACC_INIT,
    DP_MUL_SQ_INIT,
    DP_MUL_AB_INIT,
    DP_MUL_DIV_INIT,
    DP_MUL_STEP,
    DP_MUL_ACC_DONE,
    DP_MUL_TO_BASE,
    DP_MUL_TO_ACC,
    DP_PUBLISH
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_DISPATCH,
    S_POW_CHK,
    S_MUL_ACC,
    S_MUL_SQ,
    S_MUL_FIN,
    S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       red_done;
    logic       mul_done;
    logic       e_zero;
    logic       e_lsb;
    logic       mod_small;
    logic [2:0] mode;
  } dp_status_t;

endpackage

FILE: design/mau_datapath.sv
module mau_datapath import mau_pkg::*; #(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic [MOD_WIDTH-1:0] modulus,
  input  logic [2:0]           in_mode,
  input  logic [30:0]          in_a,
  input  logic [62:0]          in_b,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [30:0]          result
);

  localparam int MW = MOD_WIDTH;
  localparam int EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

  logic [2:0]    mode;
  logic [63:0]   sh;
  logic [62:0]   bq;
  logic [6:0]    cnt;
  logic [MW-1:0] rem;
  logic [MW-1:0] ra;
  logic [MW-1:0] rb;
  logic [MW-1:0] acc;
  logic [MW-1:0] base;
  logic [EW-1:0] e;
  logic [MW-1:0] x;
  logic [MW-1:0] y;
  logic [MW-1:0] p;
  logic [MW-1:0] res;

  logic [MW:0]   m_ext;
  logic [MW:0]   rem_t;
  logic [MW-1:0] rem_next;
  logic [MW:0]   p_t;
  logic [MW-1:0] p_next;
  logic [MW:0]   x_t;
  logic [MW-1:0] x_next;
  logic [MW:0]   sum_t;
  logic [MW-1:0] add_res;
  logic [MW:0]   dif_t;
  logic [MW-1:0] sub_res;
  logic [63:0]   b64;
  logic [EW-1:0] e_from_b;
  logic [EW-1:0] e_from_m;
  logic [MW-1:0] one;
  logic [63:0]   res64;

  assign m_ext = {1'b0, modulus};
  assign one   = {{(MW-1){1'b0}}, 1'b1};

  always_comb begin
    rem_t    = {rem, sh[63]};
    rem_next = (rem_t >= m_ext) ? MW'(rem_t - m_ext) : rem_t[MW-1:0];
    p_t      = {1'b0, p} + {1'b0, x};
    p_next   = (p_t >= m_ext) ? MW'(p_t - m_ext) : p_t[MW-1:0];
    x_t      = {x, 1'b0};
    x_next   = (x_t >= m_ext) ? MW'(x_t - m_ext) : x_t[MW-1:0];
    sum_t    = {1'b0, ra} + {1'b0, rb};
    add_res  = (sum_t >= m_ext) ? MW'(sum_t - m_ext) : sum_t[MW-1:0];
    dif_t    = (ra < rb) ? ({1'b0, ra} + m_ext - {1'b0, rb}) : ({1'b0, ra} - {1'b0, rb});
    sub_res  = dif_t[MW-1:0];
    b64      = {1'b0, bq};
    e_from_b = '0;
    e_from_b[EXP_WIDTH-1:0] = b64[EXP_WIDTH-1:0];
    e_from_m = '0;
    e_from_m[MW-1:0] = modulus - MW'(2);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mode <= in_mode;
        sh   <= {in_a, 33'b0};
        bq   <= in_b;
        rb   <= '0;
        cnt  <= 7'd31;
        rem  <= '0;
        ra   <= '0;
        base <= '0;
        acc  <= '0;
        e    <= '0;
        x    <= '0;
        y    <= '0;
        p    <= '0;
      end
      DP_RED_STEP: begin
        rem <= rem_next;
        sh  <= {sh[62:0], 1'b0};
        cnt <= cnt - 7'd1;
      end
      DP_SAVE_A: begin
        ra  <= rem;
        rem <= '0;
        sh  <= {bq, 1'b0};
        cnt <= 7'd63;
      end
      DP_SAVE_B: rb <= rem;
      DP_ADD:  acc <= add_res;
      DP_SUB:  acc <= sub_res;
      DP_ZERO: acc <= '0;
      DP_POW_A: begin
        acc  <= one;
        base <= ra;
        e    <= e_from_b;
      end
      DP_POW_INV_A: begin
        acc  <= one;
        base <= ra;
        e    <= e_from_m;
      end
      DP_POW_INV_B: begin
        acc  <= one;
        base <= rb;
        e    <= e_from_m;
      end
      DP_MUL_ACC_INIT: begin
        x <= acc;
        y <= base;
        p <= '0;
      end
      DP_MUL_SQ_INIT: begin
        x <= base;
        y <= base;
        p <= '0;
      end
      DP_MUL_AB_INIT: begin
        x <= ra;
        y <= rb;
        p <= '0;
      end
      DP_MUL_DIV_INIT: begin
        x <= ra;
        y <= acc;
        p <= '0;
      end
      DP_MUL_STEP: begin
        if (y[0]) begin
          p <= p_next;
        end
        x <= x_next;
        y <= y >> 1;
      end
      DP_MUL_ACC_DONE: begin
        acc <= p;
        x   <= base;
        y   <= base;
        p   <= '0;
      end
      DP_MUL_TO_BASE: begin
        base <= p;
        e    <= e >> 1;
      end
      DP_MUL_TO_ACC: acc <= p;
      DP_PUBLISH:    res <= acc;
      default: ;
    endcase
  end

  assign res64  = 64'(res);
  assign result = res64[30:0];

  always_comb begin
    status.red_done  = (cnt == 7'd0);
    status.mul_done  = (y == '0);
    status.e_zero    = (e == '0);
    status.e_lsb     = e[0];
    status.mod_small = (modulus < MW'(2));
    status.mode      = mode;
  end

endmodule

FILE: design/mau_ctrl.sv
module mau_ctrl import mau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_RED_A;
      S_RED_A:    if (status.red_done) state_next = S_RED_B;
      S_RED_B:    if (status.red_done) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (status.mod_small) begin
          state_next = S_FIN;
        end else begin
          case (status.mode)
            MODE_MUL:                     state_next = S_MUL_FIN;
            MODE_DIV, MODE_POW, MODE_INV: state_next = S_POW_CHK;
            default:                      state_next = S_FIN;
          endcase
        end
      end
      S_POW_CHK: begin
        if (status.e_zero) begin
          state_next = (status.mode == MODE_DIV) ? S_MUL_FIN : S_FIN;
        end else if (status.e_lsb) begin
          state_next = S_MUL_ACC;
        end else begin
          state_next = S_MUL_SQ;
        end
      end
      S_MUL_ACC: if (status.mul_done) state_next = S_MUL_SQ;
      S_MUL_SQ:  if (status.mul_done) state_next = S_POW_CHK;
      S_MUL_FIN: if (status.mul_done) state_next = S_FIN;
      S_FIN:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = DP_NOP;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_RED_A: cmd.op = status.red_done ? DP_SAVE_A : DP_RED_STEP;
      S_RED_B: cmd.op = status.red_done ? DP_SAVE_B : DP_RED_STEP;
      S_DISPATCH: begin
        if (status.mod_small) begin
          cmd.op = DP_ZERO;
        end else begin
          case (status.mode)
            MODE_ADD: cmd.op = DP_ADD;
            MODE_SUB: cmd.op = DP_SUB;
            MODE_MUL: cmd.op = DP_MUL_AB_INIT;
            MODE_DIV: cmd.op = DP_POW_INV_B;
            MODE_POW: cmd.op = DP_POW_A;
            MODE_INV: cmd.op = DP_POW_INV_A;
            default:  cmd.op = DP_ZERO;
          endcase
        end
      end
      S_POW_CHK: begin
        if (status.e_zero) begin
          cmd.op = (status.mode == MODE_DIV) ? DP_MUL_DIV_INIT : DP_NOP;
        end else if (status.e_lsb) begin
          cmd.op = DP_MUL_ACC_INIT;
        end else begin
          cmd.op = DP_MUL_SQ_INIT;
        end
      end
      S_MUL_ACC: cmd.op = status.mul_done ? DP_MUL_ACC_DONE : DP_MUL_STEP;
      S_MUL_SQ:  cmd.op = status.mul_done ? DP_MUL_TO_BASE : DP_MUL_STEP;
      S_MUL_FIN: cmd.op = status.mul_done ? DP_MUL_TO_ACC : DP_MUL_STEP;
      S_FIN:     if (out_free) cmd.op = DP_PUBLISH;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

FILE: design/modular_arithmetic_unit.sv
// operands are reduced bit-serially modulo the modulus (a, then b); add/subtract then finish,
// multiply runs the bit-serial shift-add multiplier, and power, inverse and divide run it for
// each exponent bit: a multiply when the bit is set, then a square
// one request is in flight at a time; a finished result waits in the output register
// rst is synchronous active high: modulus returns to 998244353, no result pending
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF,
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // mode[2:0], operand_a[33:3], operand_b[96:34]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // result[30:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [MOD_WIDTH-1:0] modulus;
  logic [63:0]          wext;
  logic [63:0]          rext;
  logic [63:0]          rst_val;
  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [30:0]          result;

  assign pready  = 1'b1;
  assign wext    = 64'(pwdata[30:0]);
  assign rst_val = MODULUS_RESET;
  assign rext    = 64'(modulus);
  assign prdata  = {1'b0, rext[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= rst_val[MOD_WIDTH-1:0];
    end else if (psel && penable && pwrite && paddr[2] == REG_MODULUS) begin
      modulus <= wext[MOD_WIDTH-1:0];
    end
  end

  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mau_datapath #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .modulus (modulus),
    .in_mode (s_tdata[2:0]),
    .in_a    (s_tdata[33:3]),
    .in_b    (s_tdata[96:34]),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

  assign m_tdata = {1'b0, result};

endmodule
